[rtl/dthcm_pkg.sv]
// Shared constants for the depth to hue colour map.
`default_nettype none

package dthcm_pkg;

  localparam int DEPTH_W = 16;
  localparam int COLOR_W = 8;
  localparam int CFG_IDX_W = 1;
  localparam int SECTOR_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RANGE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE = 1'b1;

  localparam logic [DEPTH_W-1:0] MIN_RANGE_RESET = 16'h0000;
  localparam logic [DEPTH_W-1:0] MAX_RANGE_RESET = 16'hFFFF;

  localparam logic [COLOR_W-1:0] FULL_SCALE = 8'd255;
  localparam logic [COLOR_W-1:0] ZERO_SCALE = 8'd0;

  localparam logic [SECTOR_W-1:0] SECTOR_RED_YELLOW = 3'd0;
  localparam logic [SECTOR_W-1:0] SECTOR_YELLOW_GREEN = 3'd1;
  localparam logic [SECTOR_W-1:0] SECTOR_GREEN_CYAN = 3'd2;
  localparam logic [SECTOR_W-1:0] SECTOR_CYAN_BLUE = 3'd3;
  localparam logic [SECTOR_W-1:0] SECTOR_BLUE_MAGENTA = 3'd4;

endpackage

`default_nettype wire

[rtl/dthcm_front.sv]
// Input stage: zero detection, clamping and setup of the hue division.
`default_nettype none

module dthcm_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [dthcm_pkg::DEPTH_W-1:0] depth,
  input  wire logic [dthcm_pkg::DEPTH_W-1:0] min_range,
  input  wire logic [dthcm_pkg::DEPTH_W-1:0] max_range,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [dthcm_pkg::DEPTH_W-1:0]     num,
  output logic [dthcm_pkg::DEPTH_W-1:0]     den,
  output logic                              zero
);

  logic [dthcm_pkg::DEPTH_W-1:0] upper_clamped;
  logic [dthcm_pkg::DEPTH_W-1:0] clamped;
  logic                          range_ok;
  logic [dthcm_pkg::DEPTH_W-1:0] num_next;
  logic [dthcm_pkg::DEPTH_W-1:0] den_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    upper_clamped = (depth > max_range) ? max_range : depth;
    clamped = (upper_clamped < min_range) ? min_range : upper_clamped;
    range_ok = max_range > min_range;
    // An empty or inverted range divides zero by one, which gives hue zero.
    if (range_ok) begin
      num_next = clamped - min_range;
      den_next = max_range - min_range;
    end else begin
      num_next = '0;
      den_next = {{(dthcm_pkg::DEPTH_W-1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      num  <= num_next;
      den  <= den_next;
      zero <= (depth == '0);
    end
  end

endmodule

`default_nettype wire

[rtl/dthcm_div_step.sv]
// One pipelined restoring division step that yields one quotient bit.
`default_nettype none

module dthcm_div_step #(
  parameter int QW = 19,
  parameter bit FIRST = 1'b0
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [dthcm_pkg::DEPTH_W-1:0] rem_in,
  input  wire logic [dthcm_pkg::DEPTH_W-1:0] den_in,
  input  wire logic [QW-1:0]                q_in,
  input  wire logic                         zero_in,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [dthcm_pkg::DEPTH_W-1:0]     rem_out,
  output logic [dthcm_pkg::DEPTH_W-1:0]     den_out,
  output logic [QW-1:0]                     q_out,
  output logic                              zero_out
);

  logic [dthcm_pkg::DEPTH_W:0] trial;
  logic [dthcm_pkg::DEPTH_W:0] diff;
  logic                        take;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    if (FIRST) begin
      trial = {1'b0, rem_in};
    end else begin
      trial = {rem_in, 1'b0};
    end
    diff = trial - {1'b0, den_in};
    take = trial >= {1'b0, den_in};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      rem_out  <= take ? diff[dthcm_pkg::DEPTH_W-1:0] : trial[dthcm_pkg::DEPTH_W-1:0];
      den_out  <= den_in;
      q_out    <= {q_in[QW-2:0], take};
      zero_out <= zero_in;
    end
  end

endmodule

`default_nettype wire

[rtl/dthcm_colour.sv]
// Output stage: six-sector HSV conversion of the scaled hue into blue, green and red.
`default_nettype none

module dthcm_colour #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [FRAC_BITS+2:0]          h6,
  input  wire logic                          zero,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [dthcm_pkg::COLOR_W-1:0]      blue,
  output logic [dthcm_pkg::COLOR_W-1:0]      green,
  output logic [dthcm_pkg::COLOR_W-1:0]      red
);

  logic [dthcm_pkg::SECTOR_W-1:0] sector;
  logic [FRAC_BITS-1:0]           frac;
  logic [FRAC_BITS+7:0]           up_prod;
  logic [FRAC_BITS:0]             comp;
  logic [FRAC_BITS+8:0]           down_prod;
  logic [dthcm_pkg::COLOR_W-1:0]  up;
  logic [dthcm_pkg::COLOR_W-1:0]  down;
  logic [dthcm_pkg::COLOR_W-1:0]  blue_next;
  logic [dthcm_pkg::COLOR_W-1:0]  green_next;
  logic [dthcm_pkg::COLOR_W-1:0]  red_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    sector = h6[FRAC_BITS+2:FRAC_BITS];
    frac = h6[FRAC_BITS-1:0];
    // Multiplication by 255 is a shift by eight less the operand.
    up_prod = {frac, 8'd0} - {8'd0, frac};
    comp = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, frac};
    down_prod = {comp, 8'd0} - {8'd0, comp};
    up = up_prod[FRAC_BITS+7:FRAC_BITS];
    down = down_prod[FRAC_BITS+7:FRAC_BITS];

    unique case (sector)
      dthcm_pkg::SECTOR_RED_YELLOW: begin
        red_next = dthcm_pkg::FULL_SCALE;
        green_next = up;
        blue_next = dthcm_pkg::ZERO_SCALE;
      end
      dthcm_pkg::SECTOR_YELLOW_GREEN: begin
        red_next = down;
        green_next = dthcm_pkg::FULL_SCALE;
        blue_next = dthcm_pkg::ZERO_SCALE;
      end
      dthcm_pkg::SECTOR_GREEN_CYAN: begin
        red_next = dthcm_pkg::ZERO_SCALE;
        green_next = dthcm_pkg::FULL_SCALE;
        blue_next = up;
      end
      dthcm_pkg::SECTOR_CYAN_BLUE: begin
        red_next = dthcm_pkg::ZERO_SCALE;
        green_next = down;
        blue_next = dthcm_pkg::FULL_SCALE;
      end
      dthcm_pkg::SECTOR_BLUE_MAGENTA: begin
        red_next = up;
        green_next = dthcm_pkg::ZERO_SCALE;
        blue_next = dthcm_pkg::FULL_SCALE;
      end
      default: begin
        red_next = dthcm_pkg::FULL_SCALE;
        green_next = dthcm_pkg::ZERO_SCALE;
        blue_next = down;
      end
    endcase

    if (zero) begin
      red_next = dthcm_pkg::ZERO_SCALE;
      green_next = dthcm_pkg::ZERO_SCALE;
      blue_next = dthcm_pkg::ZERO_SCALE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      blue  <= blue_next;
      green <= green_next;
      red   <= red_next;
    end
  end

endmodule

`default_nettype wire

[rtl/depth_to_hue_color_map.sv]
// Top level of the depth to hue colour map with its range registers.
`default_nettype none

// Each nonzero 16-bit depth pixel is clamped to the programmed range and coloured along
// the hue wheel from red at min_range to blue at max_range; a zero pixel gives black.
// One transaction is accepted per clock unless the output stalls. The result passes
// through the front register, the divider, which resolves one quotient bit per stage,
// and the colour register. Stages without a transaction do not block the input, so a
// stalled output holds back only as many transactions as the pipeline has stages.
// Range registers are written through cfg_we, cfg_index and cfg_data, and take effect
// for pixels accepted afterwards; they are meant to change only while the block is idle.
module depth_to_hue_color_map #(
  parameter int HUE_FRAC_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [dthcm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dthcm_pkg::DEPTH_W-1:0]   cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [dthcm_pkg::DEPTH_W-1:0]   depth,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [dthcm_pkg::COLOR_W-1:0]        blue,
  output logic [dthcm_pkg::COLOR_W-1:0]        green,
  output logic [dthcm_pkg::COLOR_W-1:0]        red
);

  localparam int QW = HUE_FRAC_BITS + 3;

  logic [dthcm_pkg::DEPTH_W-1:0] min_range;
  logic [dthcm_pkg::DEPTH_W-1:0] max_range;

  logic                          valid_s [0:QW];
  logic                          ready_s [0:QW];
  logic [dthcm_pkg::DEPTH_W-1:0] rem_s   [0:QW];
  logic [dthcm_pkg::DEPTH_W-1:0] den_s   [0:QW];
  logic [QW-1:0]                 q_s     [0:QW];
  logic                          zero_s  [0:QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      min_range <= dthcm_pkg::MIN_RANGE_RESET;
      max_range <= dthcm_pkg::MAX_RANGE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dthcm_pkg::CFG_MIN_RANGE: min_range <= cfg_data;
        dthcm_pkg::CFG_MAX_RANGE: max_range <= cfg_data;
        default: ;
      endcase
    end
  end

  dthcm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .depth     (depth),
    .min_range (min_range),
    .max_range (max_range),
    .out_valid (valid_s[0]),
    .out_ready (ready_s[0]),
    .num       (rem_s[0]),
    .den       (den_s[0]),
    .zero      (zero_s[0])
  );

  assign q_s[0] = '0;

  for (genvar k = 0; k < QW; k++) begin : g_div
    dthcm_div_step #(
      .QW    (QW),
      .FIRST (k == 0)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid_s[k]),
      .in_ready  (ready_s[k]),
      .rem_in    (rem_s[k]),
      .den_in    (den_s[k]),
      .q_in      (q_s[k]),
      .zero_in   (zero_s[k]),
      .out_valid (valid_s[k+1]),
      .out_ready (ready_s[k+1]),
      .rem_out   (rem_s[k+1]),
      .den_out   (den_s[k+1]),
      .q_out     (q_s[k+1]),
      .zero_out  (zero_s[k+1])
    );
  end

  dthcm_colour #(
    .FRAC_BITS (HUE_FRAC_BITS)
  ) u_colour (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid_s[QW]),
    .in_ready  (ready_s[QW]),
    .h6        (q_s[QW]),
    .zero      (zero_s[QW]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .blue      (blue),
    .green     (green),
    .red       (red)
  );

  a_empty_pipe_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input not ready although the output is empty");

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_hsv_full_channel: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (red == dthcm_pkg::FULL_SCALE || green == dthcm_pkg::FULL_SCALE ||
                   blue == dthcm_pkg::FULL_SCALE ||
                   (red == dthcm_pkg::ZERO_SCALE && green == dthcm_pkg::ZERO_SCALE &&
                    blue == dthcm_pkg::ZERO_SCALE)))
    else $error("colour has no saturated channel and is not black");

  a_hsv_empty_channel: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (red == dthcm_pkg::ZERO_SCALE || green == dthcm_pkg::ZERO_SCALE ||
                   blue == dthcm_pkg::ZERO_SCALE))
    else $error("colour has no empty channel");

endmodule

`default_nettype wire

[verif/tb_depth_to_hue_color_map.sv]
// Testbench for the depth to hue colour map: directed and random pixels checked by a predictor.
`timescale 1ns / 1ps

module tb_depth_to_hue_color_map;

  localparam int DEPTH_W = dthcm_pkg::DEPTH_W;
  localparam int COLOR_W = dthcm_pkg::COLOR_W;
  localparam int CFG_IDX_W = dthcm_pkg::CFG_IDX_W;
  localparam int FRAC = 16;
  localparam int PIPE_LATENCY = FRAC + 5;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int IDLE_PERCENT = 16;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } color_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = dthcm_pkg::CFG_MIN_RANGE;
  logic [DEPTH_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [DEPTH_W-1:0] depth = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [COLOR_W-1:0] blue;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] red;

  logic [DEPTH_W-1:0] range_lo = dthcm_pkg::MIN_RANGE_RESET;
  logic [DEPTH_W-1:0] range_hi = dthcm_pkg::MAX_RANGE_RESET;
  color_t expected_colors[$];
  int unsigned pixels_sent = 0;
  int unsigned colors_checked = 0;
  int unsigned settings_used = 0;
  int unsigned fail_count = 0;
  int unsigned stall_request = 0;
  bit calm = 1'b0;

  depth_to_hue_color_map #(
    .HUE_FRAC_BITS(FRAC)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .depth(depth),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .blue(blue),
    .green(green),
    .red(red)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic color_t predict_color(logic [DEPTH_W-1:0] d, logic [DEPTH_W-1:0] lo,
                                           logic [DEPTH_W-1:0] hi);
    logic [DEPTH_W-1:0] c;
    logic [39:0] h6;
    logic [39:0] sector;
    logic [39:0] f;
    logic [39:0] up;
    logic [39:0] down;
    color_t px;
    if (d == '0) begin
      px = '{dthcm_pkg::ZERO_SCALE, dthcm_pkg::ZERO_SCALE, dthcm_pkg::ZERO_SCALE};
      return px;
    end
    c = d;
    if (c > hi) c = hi;
    if (c < lo) c = lo;
    if (hi > lo) begin
      h6 = (40'(c - lo) << (FRAC + 2)) / 40'(hi - lo);
    end else begin
      h6 = '0;
    end
    sector = h6 >> FRAC;
    f = h6 & ((40'd1 << FRAC) - 40'd1);
    up = (f * 40'd255) >> FRAC;
    down = (((40'd1 << FRAC) - f) * 40'd255) >> FRAC;
    case (sector)
      40'(dthcm_pkg::SECTOR_RED_YELLOW):
        px = '{dthcm_pkg::ZERO_SCALE, up[7:0], dthcm_pkg::FULL_SCALE};
      40'(dthcm_pkg::SECTOR_YELLOW_GREEN):
        px = '{dthcm_pkg::ZERO_SCALE, dthcm_pkg::FULL_SCALE, down[7:0]};
      40'(dthcm_pkg::SECTOR_GREEN_CYAN):
        px = '{up[7:0], dthcm_pkg::FULL_SCALE, dthcm_pkg::ZERO_SCALE};
      40'(dthcm_pkg::SECTOR_CYAN_BLUE):
        px = '{dthcm_pkg::FULL_SCALE, down[7:0], dthcm_pkg::ZERO_SCALE};
      40'(dthcm_pkg::SECTOR_BLUE_MAGENTA):
        px = '{dthcm_pkg::FULL_SCALE, dthcm_pkg::ZERO_SCALE, up[7:0]};
      default:
        px = '{down[7:0], dthcm_pkg::ZERO_SCALE, dthcm_pkg::FULL_SCALE};
    endcase
    return px;
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  function automatic logic [DEPTH_W-1:0] pick_depth(logic [DEPTH_W-1:0] lo,
                                                   logic [DEPTH_W-1:0] hi);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 8) return '0;
    if (roll < 28) return DEPTH_W'($urandom);
    if (roll < 36) return ($urandom_range(1) == 0) ? lo : hi;
    return DEPTH_W'($urandom_range(int'(lo), int'(hi)));
  endfunction

  // Receiver: random stalls, calm stretches and long hold-offs on request.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (stall_request != 0) begin
        hold_left = stall_request;
        stall_request = 0;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // Checks every result transaction against the oldest prediction.
  always @(posedge clk) begin
    color_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_colors.size() == 0) begin
        note_failure($sformatf("Unexpected colour b=%0d g=%0d r=%0d", blue, green, red));
      end else begin
        want = expected_colors.pop_front();
        colors_checked++;
        if (blue !== want.blue || green !== want.green || red !== want.red) begin
          note_failure($sformatf("Colour %0d: expected b=%0d g=%0d r=%0d, got b=%0d g=%0d r=%0d",
                                 colors_checked, want.blue, want.green, want.red,
                                 blue, green, red));
        end
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic send_pixel(logic [DEPTH_W-1:0] d);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PERCENT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    depth <= d;
    do @(posedge clk); while (!in_ready);
    expected_colors.push_back(predict_color(d, range_lo, range_hi));
    pixels_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_colors.size() != 0) @(posedge clk);
  endtask

  task automatic apply_ranges(logic [DEPTH_W-1:0] lo, logic [DEPTH_W-1:0] hi);
    drain_results();
    repeat (PIPE_LATENCY) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= dthcm_pkg::CFG_MIN_RANGE;
    cfg_data <= lo;
    @(posedge clk);
    cfg_index <= dthcm_pkg::CFG_MAX_RANGE;
    cfg_data <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    range_lo = lo;
    range_hi = hi;
    settings_used++;
  endtask

  task automatic test_default_ranges();
    logic [DEPTH_W-1:0] picks[8];
    picks = '{16'h0000, 16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA, 16'h2AAA};
    settings_used++;
    foreach (picks[i]) send_pixel(picks[i]);
  endtask

  task automatic test_clamp_and_degenerate();
    apply_ranges(16'd1000, 16'd2000);
    send_pixel(16'd1);
    send_pixel(16'd999);
    send_pixel(16'd1000);
    send_pixel(16'd1500);
    send_pixel(16'd2000);
    send_pixel(16'd2001);
    send_pixel(16'hFFFF);
    apply_ranges(16'd3000, 16'd1000);
    send_pixel(16'd5);
    send_pixel(16'd2000);
    send_pixel(16'hFFFF);
    apply_ranges(16'd500, 16'd500);
    send_pixel(16'd500);
    send_pixel(16'd7);
  endtask

  task automatic test_sector_edges();
    apply_ranges(16'd0, 16'd4);
    for (int i = 1; i <= 4; i++) send_pixel(DEPTH_W'(i));
  endtask

  task automatic test_random_ranges();
    logic [DEPTH_W-1:0] los[14];
    logic [DEPTH_W-1:0] his[14];
    los = '{16'd0, 16'd0, 16'd65534, 16'd65535, 16'd0, 16'd65535, 16'd1, 16'd100,
            16'd40000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
    his = '{16'd65535, 16'd1, 16'd65535, 16'd0, 16'd0, 16'd65535, 16'd65535, 16'd356,
            16'd20000, 16'd6, 16'd0, 16'd0, 16'd0, 16'd0};
    for (int i = 10; i < 14; i++) begin
      los[i] = DEPTH_W'($urandom);
      his[i] = DEPTH_W'($urandom);
    end
    foreach (los[p]) begin
      apply_ranges(los[p], his[p]);
      calm = (p == 2);
      for (int n = 0; n < 130; n++) send_pixel(pick_depth(range_lo, range_hi));
      calm = 1'b0;
    end
  endtask

  task automatic test_output_stall();
    apply_ranges(DEPTH_W'($urandom_range(2000)), DEPTH_W'($urandom_range(65535, 30000)));
    stall_request = 300;
    for (int n = 0; n < 100; n++) send_pixel(pick_depth(range_lo, range_hi));
    drain_results();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_ranges();
    test_clamp_and_degenerate();
    test_sector_edges();
    test_random_ranges();
    test_output_stall();
    drain_results();
    repeat (PIPE_LATENCY + 8) @(posedge clk);
    while (expected_colors.size() != 0) begin
      void'(expected_colors.pop_front());
      note_failure("A predicted colour never arrived");
    end
    $display("Sent %0d pixels under %0d range settings; %0d colours checked, %0d failures.",
             pixels_sent, settings_used, colors_checked, fail_count);
    $display("Covered zero pixels, clamping, empty and inverted ranges, sector edges, stalls.");
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
